// File: rtl/pva_pkg.sv
package pva_pkg;

    localparam int OP_W          = 2;
    localparam int NOTE_W        = 7;
    localparam int MASK_W        = 6;
    localparam int VOICE_FIELD_W = 3;

    typedef logic [OP_W-1:0]          t_op;
    typedef logic [NOTE_W-1:0]        t_note;
    typedef logic [MASK_W-1:0]        t_mask;
    typedef logic [VOICE_FIELD_W-1:0] t_voice_field;

    localparam t_op OP_NOTE_ON  = 2'd0;
    localparam t_op OP_NOTE_OFF = 2'd1;
    localparam t_op OP_PANIC    = 2'd2;
    localparam t_op OP_NONE     = 2'd3;

endpackage

// File: rtl/pva_pick.sv
module pva_pick #(
    parameter int NUM_VOICES = 6,
    parameter int AGE_BITS   = 8
) (
    input  logic [NUM_VOICES-1:0]               i_on,
    input  logic [NUM_VOICES-1:0]               i_busy,
    input  logic [NUM_VOICES-1:0][AGE_BITS-1:0] i_age_inc,
    output logic [NUM_VOICES-1:0]               o_claim,
    output logic [NUM_VOICES-1:0]               o_incr
);
    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    logic [NUM_VOICES-1:0] free;
    logic [NUM_VOICES-1:0] first_free;
    logic [NUM_VOICES-1:0] off;
    logic [NUM_VOICES-1:0] first_off;
    logic [NUM_VOICES-1:0] oldest;
    logic [IDX_W-1:0]      best;
    logic [AGE_BITS-1:0]   best_age;

    // lowest set bit by two's complement
    assign free       = ~i_busy;
    assign first_free = free & (~free + NUM_VOICES'(1));
    assign off        = ~i_on;
    assign first_off  = off & (~off + NUM_VOICES'(1));

    // every voice below the first free one is busy; with none free all age
    assign o_incr = (first_free != '0) ? (first_free - NUM_VOICES'(1)) : '1;

    // oldest voice, strictly greater wins so ties keep the lower index
    always_comb begin
        best     = '0;
        best_age = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (i_age_inc[i] > best_age) begin
                best_age = i_age_inc[i];
                best     = IDX_W'(i);
            end
        end
    end

    assign oldest = NUM_VOICES'(1) << best;

    always_comb begin
        if (first_free != '0) begin
            o_claim = first_free;
        end else if (first_off != '0) begin
            o_claim = first_off;
        end else begin
            o_claim = oldest;
        end
    end

endmodule

// File: rtl/poly_voice_allocator.sv
// Polyphonic voice allocator with oldest-voice stealing. Each transaction on
// the input channel carries an operation (note on, note off, panic), a note
// number and the envelope engine's releasing mask; each produces exactly one
// result transaction carrying the assigned voice (zero unless note on) and the
// on flags of the voices after the operation. Note on takes the first voice
// that is neither on nor releasing, else the first voice that is off but
// releasing, else steals the oldest voice (lowest index on equal ages); busy
// voices scanned before the chosen free one have their age advanced with wrap,
// and with no voice free every other voice ages. One transaction is accepted
// every cycle when the result side keeps up. Each passes through an input
// register, then a read-modify-write of the voice table into the result
// register; that table update sets the rate. Only voices 0 to 5 see the
// releasing mask and report in the active mask; the assigned voice field
// carries the low three bits of the voice index.
module poly_voice_allocator #(
    parameter int NUM_VOICES = 6,
    parameter int AGE_BITS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pva_pkg::t_op          i_operation,
    input  pva_pkg::t_note        i_note,
    input  pva_pkg::t_mask        i_releasing_mask,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pva_pkg::t_voice_field o_assigned_voice,
    output pva_pkg::t_mask        o_active_mask
);
    import pva_pkg::*;

    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    // input register
    logic  r_s1_valid;
    t_op   r_op;
    t_note r_note_in;
    t_mask r_rel;

    // voice table
    logic  [NUM_VOICES-1:0]               r_on;
    t_note [NUM_VOICES-1:0]               r_voice_note;
    logic  [NUM_VOICES-1:0][AGE_BITS-1:0] r_age;

    // result register
    logic         r_out_valid;
    t_voice_field r_assigned;
    t_mask        r_active;

    logic                               s2_take;
    logic                               fire;
    logic [NUM_VOICES-1:0]              rel;
    logic [NUM_VOICES-1:0]              busy;
    logic [NUM_VOICES-1:0][AGE_BITS-1:0] age_inc;
    logic [NUM_VOICES-1:0]              claim;
    logic [NUM_VOICES-1:0]              incr;
    logic [NUM_VOICES-1:0]              match;
    logic [IDX_W-1:0]                   claim_idx;

    logic  [NUM_VOICES-1:0]               n_on;
    t_note [NUM_VOICES-1:0]               n_voice_note;
    logic  [NUM_VOICES-1:0][AGE_BITS-1:0] n_age;
    t_voice_field                         n_assigned;

    // advance the input register whenever the result register frees up
    assign s2_take    = !r_out_valid || i_out_ready;
    assign fire       = r_s1_valid && s2_take;
    assign o_in_ready = !r_s1_valid || s2_take;

    // voices beyond the mask width never count as releasing
    assign rel  = NUM_VOICES'(r_rel);
    assign busy = r_on | rel;

    always_comb begin
        for (int i = 0; i < NUM_VOICES; i++) begin
            age_inc[i] = r_age[i] + AGE_BITS'(1);
            match[i]   = r_on[i] && (r_voice_note[i] == r_note_in);
        end
    end

    pva_pick #(
        .NUM_VOICES (NUM_VOICES),
        .AGE_BITS   (AGE_BITS)
    ) u_pick (
        .i_on      (r_on),
        .i_busy    (busy),
        .i_age_inc (age_inc),
        .o_claim   (claim),
        .o_incr    (incr)
    );

    // encode the one-hot claim
    always_comb begin
        claim_idx = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (claim[i]) begin
                claim_idx = claim_idx | IDX_W'(i);
            end
        end
    end

    // next state of the voice table for the held operation
    always_comb begin
        n_on         = r_on;
        n_voice_note = r_voice_note;
        n_age        = r_age;
        n_assigned   = '0;
        unique case (r_op)
            OP_NOTE_ON: begin
                n_on       = r_on | claim;
                n_assigned = VOICE_FIELD_W'(claim_idx);
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (claim[i]) begin
                        n_voice_note[i] = r_note_in;
                        n_age[i]        = '0;
                    end else if (incr[i]) begin
                        n_age[i] = age_inc[i];
                    end
                end
            end
            OP_NOTE_OFF: begin
                n_on = r_on & ~match;
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (match[i]) begin
                        n_age[i] = '0;
                    end
                end
            end
            OP_PANIC: begin
                n_on  = '0;
                n_age = '0;
            end
            default: begin
                // unused code: hold the table
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_on         <= '0;
            r_voice_note <= '0;
            r_age        <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_take) begin
                r_out_valid <= r_s1_valid;
            end
            if (fire) begin
                r_on         <= n_on;
                r_voice_note <= n_voice_note;
                r_age        <= n_age;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op      <= i_operation;
            r_note_in <= i_note;
            r_rel     <= i_releasing_mask;
        end
        if (fire) begin
            r_assigned <= n_assigned;
            r_active   <= MASK_W'(n_on);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_assigned_voice = r_assigned;
    assign o_active_mask    = r_active;

    // note on always picks exactly one voice
    a_claim_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_op == OP_NOTE_ON) |-> $onehot(claim))
        else $error("note on did not pick exactly one voice");

    // while a free voice exists, the claimed voice is not among those aged
    a_claim_not_aged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_op == OP_NOTE_ON) && (incr != '1) |-> ((claim & incr) == '0))
        else $error("claimed voice also aged");

    // the claimed voice is on after the transaction
    a_claim_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_op == OP_NOTE_ON) |=> ((r_on & $past(claim)) == $past(claim)))
        else $error("claimed voice not on");

    // panic leaves every voice off
    a_panic_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_op == OP_PANIC) |=> (r_on == '0) && (o_active_mask == '0))
        else $error("voices still on after panic");

endmodule

// File: bench/poly_voice_allocator_tb.sv
module poly_voice_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pva_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 6;
    localparam int NUM_VOICES    = 6;
    localparam int AGE_BITS      = 8;
    localparam int N_WARMUP      = 25;
    localparam int RANDOM_ITEMS  = 1250;
    // the final stretch of the run goes without any idling on either side
    localparam int CALM_TAIL     = 150;
    // leave a comfortable margin after the last result
    localparam int SETTLE_CYCLES = 8;
    // longest correct quiet spell: sender gap + receiver stall + latency, well under this
    localparam int STALL_LIMIT   = 400;

    // one result transaction: the voice handed out and the on flags afterwards
    typedef struct packed {
        t_voice_field voice;
        t_mask        active;
    } t_alloc_result;

    // one row of the opening table; fixed rows carry a result typed in by hand
    typedef struct packed {
        t_op          op;
        t_note        note;
        t_mask        releasing;
        logic         fixed;
        t_voice_field voice;
        t_mask        active;
    } t_warmup_row;

    logic         i_clk            = 1'b0;
    logic         i_rst_n          = 1'b0;
    logic         i_in_valid       = 1'b0;
    logic         i_out_ready      = 1'b0;
    t_op          i_operation      = OP_NONE;
    t_note        i_note           = '0;
    t_mask        i_releasing_mask = '0;
    logic         o_in_ready;
    logic         o_out_valid;
    t_voice_field o_assigned_voice;
    t_mask        o_active_mask;

    poly_voice_allocator #(
        .NUM_VOICES (NUM_VOICES),
        .AGE_BITS   (AGE_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_note           (i_note),
        .i_releasing_mask (i_releasing_mask),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_assigned_voice (o_assigned_voice),
        .o_active_mask    (o_active_mask)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Opening table. Rows marked fixed carry a result that is plain from the
    // behaviour (reset state, panic, the unused code, the first fills, a tied
    // steal); all the others take their result from the voice table below.
    t_warmup_row warmup_rows [N_WARMUP] = '{
        // nothing sounds after reset, so a note off finds nothing
        '{OP_NOTE_OFF, 7'd0,   6'h00, 1'b1, 3'd0, 6'h00},
        // the unused code must leave the table alone
        '{OP_NONE,     7'd127, 6'h3f, 1'b1, 3'd0, 6'h00},
        '{OP_PANIC,    7'd127, 6'h3f, 1'b1, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd0,   6'h00, 1'b1, 3'd0, 6'h01},
        '{OP_NOTE_ON,  7'd127, 6'h00, 1'b1, 3'd1, 6'h03},
        // every remaining voice still releasing: take the first one that is off
        '{OP_NOTE_ON,  7'd60,  6'h3c, 1'b0, 3'd0, 6'h00},
        // same note on two voices, then one note off clears both
        '{OP_NOTE_ON,  7'd60,  6'h00, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_OFF, 7'd60,  6'h15, 1'b0, 3'd0, 6'h00},
        // note off for a note that nobody holds
        '{OP_NOTE_OFF, 7'd99,  6'h3f, 1'b0, 3'd0, 6'h00},
        // fill the table with everything releasing
        '{OP_NOTE_ON,  7'd1,   6'h3f, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd2,   6'h3f, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd3,   6'h3f, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd4,   6'h3f, 1'b0, 3'd0, 6'h00},
        // table full: steal the oldest, twice
        '{OP_NOTE_ON,  7'd5,   6'h00, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd6,   6'h3f, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_OFF, 7'd127, 6'h2a, 1'b0, 3'd0, 6'h00},
        '{OP_PANIC,    7'd0,   6'h00, 1'b1, 3'd0, 6'h00},
        // claim the voices top down so that every age ends up level
        '{OP_NOTE_ON,  7'd10,  6'h1f, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd11,  6'h0f, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd12,  6'h07, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd13,  6'h03, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd14,  6'h01, 1'b0, 3'd0, 6'h00},
        '{OP_NOTE_ON,  7'd15,  6'h00, 1'b0, 3'd0, 6'h00},
        // steal with every age tied: the lowest voice goes
        '{OP_NOTE_ON,  7'd16,  6'h3f, 1'b1, 3'd0, 6'h3f},
        '{OP_NOTE_ON,  7'd127, 6'h2a, 1'b0, 3'd0, 6'h00}
    };

    // Voice table mirrored from the accepted transactions.
    t_note                held_note [NUM_VOICES];
    logic                 is_on     [NUM_VOICES];
    logic [AGE_BITS-1:0]  age_count [NUM_VOICES];

    t_alloc_result owed_allocations [$];
    int            mismatches    = 0;
    int            results_seen  = 0;
    int            requests_sent = 0;
    int            idle_cycles   = 0;
    int            stall_left    = 0;
    bit            calm            = 1'b0;
    bit            sender_gaps     = 1'b0;
    bit            receiver_stalls = 1'b0;
    bit            age_wrap_done   = 1'b0;

    initial begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            held_note[v] = '0;
            is_on[v]     = 1'b0;
            age_count[v] = '0;
        end
    end

    function automatic t_mask on_flags();
        t_mask m;
        m = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            m[v] = is_on[v];
        end
        return m;
    endfunction

    // Apply one request to the voice table and work out its result.
    task automatic allocate_voice(input t_op op, input t_note note, input t_mask releasing,
                                  output t_alloc_result res);
        int                  chosen;
        bit                  placed;
        logic [AGE_BITS-1:0] oldest;
        chosen = 0;
        placed = 1'b0;
        oldest = '0;
        case (op)
            OP_NOTE_ON: begin
                // age every busy voice passed on the way to the first free one
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (!placed) begin
                        if (is_on[v] || releasing[v]) begin
                            age_count[v] = age_count[v] + 1'b1;
                        end else begin
                            chosen = v;
                            placed = 1'b1;
                        end
                    end
                end
                // no free voice: fall back on the first one that is off
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (!placed && !is_on[v]) begin
                        chosen = v;
                        placed = 1'b1;
                    end
                end
                // all on: steal the strictly oldest, lowest index on a tie
                if (!placed) begin
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (age_count[v] > oldest) begin
                            oldest = age_count[v];
                            chosen = v;
                        end
                    end
                end
                held_note[chosen] = note;
                is_on[chosen]     = 1'b1;
                age_count[chosen] = '0;
            end
            OP_NOTE_OFF: begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (is_on[v] && held_note[v] == note) begin
                        is_on[v]     = 1'b0;
                        age_count[v] = '0;
                    end
                end
            end
            OP_PANIC: begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                    is_on[v]     = 1'b0;
                    age_count[v] = '0;
                end
            end
            default: begin
            end
        endcase
        res.voice  = (op == OP_NOTE_ON) ? t_voice_field'(chosen) : '0;
        res.active = on_flags();
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t, result %0d: %s got %0d want %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Present one request and hold it until the transaction completes. Call and
    // return at a falling edge; valid stays high so back-to-back requests need
    // no second assignment in the same step.
    task automatic send_request(input t_op op, input t_note note, input t_mask releasing,
                                input logic fixed, input t_alloc_result fixed_result);
        t_alloc_result res;
        int            gap;
        if (sender_gaps && !calm && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_note           <= note;
        i_releasing_mask <= releasing;
        do @(posedge i_clk); while (!o_in_ready);
        // book the result at the next falling edge, ahead of any result edge
        @(negedge i_clk);
        allocate_voice(op, note, releasing, res);
        owed_allocations.push_back(fixed ? fixed_result : res);
        requests_sent++;
    endtask

    task automatic send_event(input t_op op, input t_note note, input t_mask releasing);
        send_request(op, note, releasing, 1'b0, t_alloc_result'('0));
    endtask

    // Drop valid and hold until every owed result is back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (owed_allocations.size() != 0);
    endtask

    function automatic t_mask pick_releasing();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2, 3:    return t_mask'($urandom) & t_mask'($urandom);
            default: return t_mask'($urandom);
        endcase
    endfunction

    // A phrase of mixed traffic. Note offs mostly aim at a held note, and some
    // phrases keep to a narrow band of notes so duplicates turn up.
    task automatic play_random_phrase(input int count);
        int    base;
        int    span;
        int    pick;
        int    v;
        t_note note;
        if ($urandom_range(0, 2) == 0) begin
            base = $urandom_range(0, 124);
            span = 3;
        end else begin
            base = 0;
            span = 127;
        end
        repeat (count) begin
            pick = $urandom_range(0, 99);
            note = t_note'(base + $urandom_range(0, span));
            if (pick < 56) begin
                send_event(OP_NOTE_ON, note, pick_releasing());
            end else if (pick < 92) begin
                v = $urandom_range(0, NUM_VOICES - 1);
                if (is_on[v] && $urandom_range(0, 9) < 8) begin
                    note = held_note[v];
                end
                send_event(OP_NOTE_OFF, note, pick_releasing());
            end else if (pick < 96) begin
                send_event(OP_PANIC, t_note'($urandom), pick_releasing());
            end else begin
                send_event(OP_NONE, t_note'($urandom), pick_releasing());
            end
        end
    endtask

    // Hold five voices and cycle the top one a couple of hundred times, so that
    // the held ages approach the wrap; the closing steals then land with some
    // ages wrapped and some not.
    task automatic cycle_top_voice();
        t_note held [5];
        t_note spare;
        logic  clash;
        int    laps;
        send_event(OP_PANIC, t_note'($urandom), pick_releasing());
        for (int k = 0; k < 5; k++) begin
            held[k] = t_note'($urandom);
            send_event(OP_NOTE_ON, held[k], '0);
        end
        do begin
            spare = t_note'($urandom);
            clash = 1'b0;
            for (int k = 0; k < 5; k++) begin
                if (held[k] == spare) begin
                    clash = 1'b1;
                end
            end
        end while (clash);
        laps = $urandom_range(248, 255);
        repeat (laps) begin
            send_event(OP_NOTE_ON, spare, pick_releasing());
            if ($urandom_range(0, 19) == 0) begin
                send_event(OP_NONE, t_note'($urandom), pick_releasing());
            end
            send_event(OP_NOTE_OFF, spare, pick_releasing());
        end
        send_event(OP_NOTE_ON, spare, pick_releasing());
        send_event(OP_NOTE_ON, t_note'($urandom), pick_releasing());
        send_event(OP_NOTE_ON, t_note'($urandom), pick_releasing());
    endtask

    // Result side: stall in random bursts while allowed, otherwise accept.
    always @(negedge i_clk) begin
        if (stall_left != 0 && !calm) begin
            stall_left = stall_left - 1;
        end else if (receiver_stalls && !calm && $urandom_range(0, 99) < 12) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each result transaction against the oldest owed one, and watch for
    // a hang: end the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results owed",
                         idle_cycles, owed_allocations.size());
                $display("== FAIL ==");
                $finish;
            end else if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (owed_allocations.size() == 0) begin
                    flag_mismatch("result with nothing owed, voice", o_assigned_voice, 0);
                end else begin
                    want = owed_allocations.pop_front();
                    if (o_assigned_voice !== want.voice) begin
                        flag_mismatch("assigned voice", o_assigned_voice, want.voice);
                    end
                    if (o_active_mask !== want.active) begin
                        flag_mismatch("active mask", o_active_mask, want.active);
                    end
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // opening table with both sides idling
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        foreach (warmup_rows[r]) begin
            send_request(warmup_rows[r].op, warmup_rows[r].note, warmup_rows[r].releasing,
                         warmup_rows[r].fixed,
                         t_alloc_result'{warmup_rows[r].voice, warmup_rows[r].active});
        end
        drain_results();

        while (requests_sent < N_WARMUP + RANDOM_ITEMS) begin
            calm            = (requests_sent >= N_WARMUP + RANDOM_ITEMS - CALM_TAIL);
            sender_gaps     = !calm && ($urandom_range(0, 9) < 7);
            receiver_stalls = !calm && ($urandom_range(0, 9) < 7);
            if (!age_wrap_done && !calm && requests_sent >= N_WARMUP + 200) begin
                cycle_top_voice();
                age_wrap_done = 1'b1;
            end else begin
                play_random_phrase($urandom_range(10, 60));
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
